// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants of the sorted priority queue
// used by spq_ctrl, spq_datapath and sorted_priority_queue_top; no dependencies
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 32;
    localparam int ACT_W        = 2;
    localparam int POS_W        = 4;
    localparam int CNT_W        = 5;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ctrl.sv =====
// spq_ctrl: controller state machine of the sorted priority queue
// sequences load, compare and update; depends on spq_pkg
`default_nettype none

module spq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output spq_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // the update cycle can overlap the next transaction's accept
    assign busy   = (r_state == ST_CMP);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = accept ? ST_CMP : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load = accept;
    assign o_cmd.cmp  = (r_state == ST_CMP);
    assign o_cmd.upd  = (r_state == ST_UPD);

    a_load_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.cmp)
        else $error("accepted transaction did not enter compare");

    a_cmp_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cmp |=> o_cmd.upd)
        else $error("compare not followed by update");

    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.cmp, o_cmd.upd}))
        else $error("compare and update active together");

endmodule

`default_nettype wire

// ===== hw/rtl/spq_datapath.sv =====
// spq_datapath: sorted entry store with parallel comparators and a parallel shift
// driven by spq_ctrl commands; depends on spq_pkg
`default_nettype none

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  spq_pkg::t_cmd                         i_cmd,
    input  wire logic [spq_pkg::ACT_W-1:0]        i_action,
    input  wire logic signed [spq_pkg::VAL_W-1:0] i_item_value,
    output logic                                  o_result_valid,
    output logic                                  o_ok,
    output logic [spq_pkg::POS_W-1:0]             o_position,
    output logic [spq_pkg::CNT_W-1:0]             o_entry_count,
    output logic signed [spq_pkg::VAL_W-1:0]      o_head_value,
    output logic                                  o_head_valid
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [spq_pkg::ACT_W-1:0]        r_action;
    logic signed [spq_pkg::VAL_W-1:0] r_value;
    logic signed [spq_pkg::VAL_W-1:0] r_entries [CAPACITY];
    logic signed [spq_pkg::VAL_W-1:0] n_entries [CAPACITY];
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [CAPACITY-1:0]              r_gt;
    logic [CAPACITY-1:0]              r_eq;

    logic                             r_done;
    logic                             r_ok;
    logic [IW-1:0]                    r_pos;
    logic signed [spq_pkg::VAL_W-1:0] r_head;
    logic                             r_head_valid;

    logic          n_ok;
    logic [IW-1:0] n_pos;
    logic [IW-1:0] ins_at;
    logic [IW-1:0] eq_at;
    logic          eq_hit;
    logic          full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_item_value;
        end
        // compare stage: every valid entry against the operand
        if (i_cmd.cmp) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_gt[i] <= (CW'(i) < r_count) && (r_entries[i] > r_value);
                r_eq[i] <= (CW'(i) < r_count) && (r_entries[i] == r_value);
            end
        end
    end

    // entries are kept descending, so the greater-than mask is a prefix
    always_comb begin
        ins_at = '0;
        eq_at  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_gt[i]) ins_at = IW'(i);
            if (r_eq[i])  eq_at  = IW'(i);
        end
    end

    assign eq_hit = |r_eq;
    assign full   = (r_count == CW'(CAPACITY));

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_ok      = 1'b0;
        n_pos     = '0;
        case (r_action)
            spq_pkg::ACT_INSERT: begin
                if (!full) begin
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (IW'(i) > ins_at) n_entries[i] = r_entries[i-1];
                    end
                    n_entries[ins_at] = r_value;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                    n_pos   = ins_at;
                end
            end
            spq_pkg::ACT_REMOVE: begin
                if (eq_hit) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (IW'(i) >= eq_at) n_entries[i] = r_entries[i+1];
                    end
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_pos   = eq_at;
                end
            end
            spq_pkg::ACT_FIND: begin
                if (eq_hit) begin
                    n_ok  = 1'b1;
                    n_pos = eq_at;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_entries    <= n_entries;
            r_ok         <= n_ok;
            r_pos        <= n_pos;
            r_head       <= (n_count != '0) ? n_entries[0] : '0;
            r_head_valid <= (n_count != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.upd;
            if (i_cmd.upd) r_count <= n_count;
        end
    end

    assign o_result_valid = r_done;
    assign o_ok           = r_ok;
    assign o_position     = spq_pkg::POS_W'(r_pos);
    assign o_entry_count  = spq_pkg::CNT_W'(r_count);
    assign o_head_value   = r_head;
    assign o_head_valid   = r_head_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.upd |=> $stable(r_count))
        else $error("entry count changed outside update");

    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_head_valid == (r_count != '0)))
        else $error("head valid disagrees with entry count");

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// sorted_priority_queue_top: descending sorted store with insert, remove and find
// the result strobe follows the compare and update states after a start transaction is accepted
// a new transaction can be accepted in the update state of the last (compare across all entries, then shift)
// the receiver cannot stall; each result is shown for exactly one cycle
// reset clears the entry count, controller state and strobe; entry storage is not cleared
`default_nettype none

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [spq_pkg::ACT_W-1:0]        i_action,
    input  wire logic signed [spq_pkg::VAL_W-1:0] i_item_value,
    output logic                                  o_result_valid,
    output logic                                  o_ok,
    output logic [spq_pkg::POS_W-1:0]             o_position,
    output logic [spq_pkg::CNT_W-1:0]             o_entry_count,
    output logic signed [spq_pkg::VAL_W-1:0]      o_head_value,
    output logic                                  o_head_valid
);

    spq_pkg::t_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_item_value   (i_item_value),
        .o_result_valid (o_result_valid),
        .o_ok           (o_ok),
        .o_position     (o_position),
        .o_entry_count  (o_entry_count),
        .o_head_value   (o_head_value),
        .o_head_valid   (o_head_valid)
    );

endmodule

`default_nettype wire

// ===== tb/spq_checker.sv =====
// spq_checker: shadow model and result scoreboard for sorted_priority_queue_top
// watches the start/busy and result strobe ports; depends on spq_pkg
`timescale 1ns / 1ps

module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             i_busy,
    input  wire logic [spq_pkg::ACT_W-1:0]        i_action,
    input  wire logic signed [spq_pkg::VAL_W-1:0] i_item_value,
    input  wire logic                             i_result_valid,
    input  wire logic                             i_ok,
    input  wire logic [spq_pkg::POS_W-1:0]        i_position,
    input  wire logic [spq_pkg::CNT_W-1:0]        i_entry_count,
    input  wire logic signed [spq_pkg::VAL_W-1:0] i_head_value,
    input  wire logic                             i_head_valid,
    input  wire logic                             i_end,
    output int                                    o_mismatches,
    output int                                    o_pending,
    output int                                    o_results
);

    typedef struct packed {
        logic                             ok;
        logic [spq_pkg::POS_W-1:0]        position;
        logic [spq_pkg::CNT_W-1:0]        entry_count;
        logic signed [spq_pkg::VAL_W-1:0] head_value;
        logic                             head_valid;
    } t_queue_status;

    // shadow copy of the sorted store, largest value first
    logic signed [spq_pkg::VAL_W-1:0] shadow_entries [CAPACITY];
    int                               shadow_count;
    t_queue_status                    expected_status [$];
    t_queue_status                    got, want;
    logic                             leftover_checked;

    initial begin
        o_mismatches     = 0;
        o_pending        = 0;
        o_results        = 0;
        shadow_count     = 0;
        leftover_checked = 1'b0;
    end

    function automatic t_queue_status apply_queue_op(
        input logic [spq_pkg::ACT_W-1:0]        act,
        input logic signed [spq_pkg::VAL_W-1:0] val);
        t_queue_status r;
        int            at;
        int            i;
        r = '0;
        if (act == spq_pkg::ACT_INSERT) begin
            if (shadow_count < CAPACITY) begin
                at = 0;
                // a new value goes ahead of equal values already stored
                while (at < shadow_count && shadow_entries[at] > val)
                    at++;
                for (i = shadow_count; i > at; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[at] = val;
                shadow_count++;
                r.ok       = 1'b1;
                r.position = at[spq_pkg::POS_W-1:0];
            end
        end else if (act == spq_pkg::ACT_REMOVE || act == spq_pkg::ACT_FIND) begin
            at = shadow_count;
            for (i = 0; i < shadow_count; i++)
                if (at == shadow_count && shadow_entries[i] == val)
                    at = i;
            if (at < shadow_count) begin
                r.ok       = 1'b1;
                r.position = at[spq_pkg::POS_W-1:0];
                if (act == spq_pkg::ACT_REMOVE) begin
                    for (i = at; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
        end
        // unused action code leaves the store alone and only reports status
        r.entry_count = shadow_count[spq_pkg::CNT_W-1:0];
        r.head_valid  = (shadow_count != 0);
        r.head_value  = (shadow_count != 0) ? shadow_entries[0] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns spq_checker: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [spq_pkg::VAL_W-1:0] seen,
                               input logic [spq_pkg::VAL_W-1:0] wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("result %0d: %s is 0x%h, expected 0x%h",
                                      o_results, name, seen, wanted));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_status.delete();
        end else begin
            // results come later than their start, so compare first
            if (i_result_valid) begin
                got.ok          = i_ok;
                got.position    = i_position;
                got.entry_count = i_entry_count;
                got.head_value  = i_head_value;
                got.head_valid  = i_head_valid;
                if (expected_status.size() == 0) begin
                    report_mismatch("result strobe with no transaction outstanding");
                end else begin
                    want = expected_status.pop_front();
                    check_field("ok", got.ok, want.ok);
                    check_field("position", got.position, want.position);
                    check_field("entry_count", got.entry_count, want.entry_count);
                    check_field("head_value", got.head_value, want.head_value);
                    check_field("head_valid", got.head_valid, want.head_valid);
                end
                o_results++;
            end
            if (i_start && !i_busy)
                expected_status.push_back(apply_queue_op(i_action, i_item_value));
            if (i_end && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_status.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_status.size()));
            end
        end
        o_pending <= expected_status.size();
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for sorted_priority_queue_top
// drives directed and random queue transactions; scoring is done by spq_checker
`timescale 1ns / 1ps

module tb;

    localparam logic [spq_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int                        RANDOM_OPS = 1600;
    localparam int                        QUIET_TAIL = 200;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             start        = 1'b0;
    logic [spq_pkg::ACT_W-1:0]        i_action     = spq_pkg::ACT_INSERT;
    logic signed [spq_pkg::VAL_W-1:0] i_item_value = '0;
    logic                             busy;
    logic                             o_result_valid;
    logic                             o_ok;
    logic [spq_pkg::POS_W-1:0]        o_position;
    logic [spq_pkg::CNT_W-1:0]        o_entry_count;
    logic signed [spq_pkg::VAL_W-1:0] o_head_value;
    logic                             o_head_valid;

    logic                             drain_done = 1'b0;
    logic                             allow_idle = 1'b1;
    int                               mismatches, pending, results;
    int                               op_count [4];
    logic signed [spq_pkg::VAL_W-1:0] recent_values [$];

    always #1 i_clk = ~i_clk;

    sorted_priority_queue_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_item_value   (i_item_value),
        .o_result_valid (o_result_valid),
        .o_ok           (o_ok),
        .o_position     (o_position),
        .o_entry_count  (o_entry_count),
        .o_head_value   (o_head_value),
        .o_head_valid   (o_head_valid)
    );

    spq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_item_value   (i_item_value),
        .i_result_valid (o_result_valid),
        .i_ok           (o_ok),
        .i_position     (o_position),
        .i_entry_count  (o_entry_count),
        .i_head_value   (o_head_value),
        .i_head_valid   (o_head_valid),
        .i_end          (drain_done),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results)
    );

    // holds start until the transaction is taken, then maybe idles a burst
    task automatic issue_op(input logic [spq_pkg::ACT_W-1:0] act,
                            input logic signed [spq_pkg::VAL_W-1:0] val);
        start        <= 1'b1;
        i_action     <= act;
        i_item_value <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        op_count[act]++;
        if (act == spq_pkg::ACT_INSERT) begin
            recent_values.push_back(val);
            if (recent_values.size() > 32)
                void'(recent_values.pop_front());
        end
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge i_clk);
        end
    endtask

    // mostly values already stored or nearby, so finds and removes hit
    function automatic logic signed [spq_pkg::VAL_W-1:0] pick_value();
        logic signed [spq_pkg::VAL_W-1:0] v;
        int                               sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && recent_values.size() != 0)
            v = recent_values[$urandom_range(0, recent_values.size() - 1)];
        else if (sel < 7)
            v = $signed($urandom_range(0, 16)) - 8;
        else if (sel == 7)
            case ($urandom_range(0, 3))
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = '0;
                default: v = -1;
            endcase
        else
            v = $urandom();
        return v;
    endfunction

    logic signed [spq_pkg::VAL_W-1:0] fill_values [16] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 5, 5, -5,
        100, -100, 32'sh4000_0000, 32'shC000_0000, 5, 7, -7, 3
    };

    initial begin
        int                               guard;
        int                               roll;
        logic                             filling;
        logic [spq_pkg::ACT_W-1:0]        act;
        logic signed [spq_pkg::VAL_W-1:0] val;

        repeat (3)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, every action
        issue_op(spq_pkg::ACT_FIND, 0);
        issue_op(spq_pkg::ACT_REMOVE, 0);
        issue_op(ACT_UNUSED, 0);
        // fill to capacity with extremes and duplicates, then overflow
        foreach (fill_values[k])
            issue_op(spq_pkg::ACT_INSERT, fill_values[k]);
        issue_op(spq_pkg::ACT_INSERT, 42);
        issue_op(spq_pkg::ACT_FIND, 5);
        issue_op(spq_pkg::ACT_FIND, 32'sh8000_0000);
        issue_op(spq_pkg::ACT_FIND, 12345);
        issue_op(spq_pkg::ACT_REMOVE, 32'sh7FFF_FFFF);
        issue_op(spq_pkg::ACT_REMOVE, 5);
        issue_op(spq_pkg::ACT_REMOVE, 32'sh8000_0000);

        // alternate fill-heavy and drain-heavy stretches so the store swings
        // between empty and full
        filling = 1'b0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 48 == 0)
                filling = ~filling;
            if (n % 100 == 0)
                allow_idle = ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_OPS - QUIET_TAIL)
                allow_idle = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                act = ACT_UNUSED;
            else if (roll < (filling ? 60 : 25))
                act = spq_pkg::ACT_INSERT;
            else if (roll < (filling ? 80 : 65))
                act = spq_pkg::ACT_REMOVE;
            else
                act = spq_pkg::ACT_FIND;
            val = pick_value();
            issue_op(act, val);
        end

        start <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8)
            @(posedge i_clk);
        drain_done = 1'b1;
        repeat (2)
            @(posedge i_clk);

        $display("tb: %0d insert, %0d remove, %0d find, %0d unused-code transactions",
                 op_count[spq_pkg::ACT_INSERT], op_count[spq_pkg::ACT_REMOVE],
                 op_count[spq_pkg::ACT_FIND], op_count[ACT_UNUSED]);
        $display("tb: %0d results checked, %0d mismatches", results, mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: timeout");
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue_top.sv
tb/spq_checker.sv
tb/tb.sv
